// ----- design/cvs_pkg.sv -----
// Shared types, codes and saturation helpers for the circle visual servo step unit.
`default_nettype none

package cvs_pkg;

    localparam int IN_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH_DEF = 2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FOCAL   = 3'd0,
        CFG_WIDTH   = 3'd1,
        CFG_HEIGHT  = 3'd2,
        CFG_DIAM    = 3'd3,
        CFG_TGT_X   = 3'd4,
        CFG_TGT_Y   = 3'd5,
        CFG_TGT_D   = 3'd6,
        CFG_TSTEP   = 3'd7
    } t_cfg_idx;

    localparam logic [31:0] RST_FOCAL  = 32'd32768000;
    localparam logic [12:0] RST_WIDTH  = 13'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [31:0] RST_DIAM   = 32'd13421773;
    localparam logic [15:0] RST_TGT_X  = 16'd5120;
    localparam logic [15:0] RST_TGT_Y  = 16'd3840;
    localparam logic [15:0] RST_TGT_D  = 16'd1600;
    localparam logic [31:0] RST_TSTEP  = 32'd2684355;

    // Classified work item handed from the front to the back.
    typedef struct packed {
        logic               no_tgt;
        logic signed [16:0] e0;
        logic signed [16:0] e1;
        logic signed [17:0] e2;
        logic signed [17:0] u;
        logic signed [17:0] v;
        logic        [15:0] rad;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] qw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
    } t_work;

    typedef struct packed {
        logic signed [31:0] cmd_x;
        logic signed [31:0] cmd_y;
        logic signed [31:0] cmd_z;
        logic               no_target;
        logic               saturated;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_UE,
        ST_DIV_S0,
        ST_WAIT_S0,
        ST_DIV_S1,
        ST_WAIT_S1,
        ST_DIV_S2,
        ST_WAIT_S2,
        ST_DIV_K,
        ST_WAIT_K,
        ST_MUL_V,
        ST_DIV_V,
        ST_WAIT_V,
        ST_MUL_Q,
        ST_ACC_Q,
        ST_ROT,
        ST_MUL_R,
        ST_ACC_R,
        ST_MUL_T,
        ST_CMD,
        ST_DONE
    } t_bk_state;

    localparam logic signed [71:0] MAX32 = 72'sd2147483647;
    localparam logic signed [71:0] MIN32 = -72'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [31:0] y;
        if (x > MAX32) begin
            y = 32'sh7fffffff;
        end else if (x < MIN32) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic ovf32(input logic signed [71:0] x);
        return (x > MAX32) || (x < MIN32);
    endfunction

endpackage

`default_nettype wire

// ----- design/circle_visual_servo_step_unit.sv -----
// Top level of the circle visual servo step unit: configuration, queues, front and back.
//
// Usage: circle measurements and the current pose enter through a queue-style
// port: an item is taken at a clock edge with push high and full low. Results
// leave through a second queue: while empty is low the oldest result sits on
// the o_cmd_*, o_no_target and o_saturated ports and is taken with pop.
// The front classifies each item combinationally (feature errors, centered
// coordinates, missing-target flag) and writes it into an input queue of
// IN_DEPTH entries, so push is accepted while the back is busy.
// The back runs one item at a time on one shared 33x33 multiplier and one
// iterative divider that retires 8 quotient bits a cycle: each item takes
// seven divisions, start plus wait, and a run of multiplies, accumulates,
// the pop and the result push; an item with zero radius goes from the pop
// straight to the result push. If the receiver stalls, finished results
// wait in the OUT_DEPTH output queue; when that fills, the back holds its
// result and the input queue keeps absorbing items until it is full.
// Reset (synchronous, active low) empties both queues, idles the back and
// loads the default configuration. Registers are written through i_cfg_we.
`default_nettype none

module circle_visual_servo_step_unit #(
    parameter int IN_DEPTH  = cvs_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = cvs_pkg::OUT_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_idx,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [15:0] i_center_x,
    input  wire logic        [15:0] i_center_y,
    input  wire logic        [15:0] i_radius,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_quat_w,
    input  wire logic signed [31:0] i_quat_x,
    input  wire logic signed [31:0] i_quat_y,
    input  wire logic signed [31:0] i_quat_z,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_cmd_x,
    output logic signed [31:0]      o_cmd_y,
    output logic signed [31:0]      o_cmd_z,
    output logic                    o_no_target,
    output logic                    o_saturated
);

    logic [31:0] r_focal;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [31:0] r_diam;
    logic [15:0] r_tgt_x;
    logic [15:0] r_tgt_y;
    logic [15:0] r_tgt_d;
    logic [31:0] r_tstep;

    cvs_pkg::t_work   fr_work;
    cvs_pkg::t_work   q_work;
    logic             work_empty;
    logic             work_pop;
    cvs_pkg::t_result bk_res;
    logic             res_push;
    logic             res_full;
    cvs_pkg::t_result out_res;

    // Hold configuration; mask each write to its register width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= cvs_pkg::RST_FOCAL;
            r_width  <= cvs_pkg::RST_WIDTH;
            r_height <= cvs_pkg::RST_HEIGHT;
            r_diam   <= cvs_pkg::RST_DIAM;
            r_tgt_x  <= cvs_pkg::RST_TGT_X;
            r_tgt_y  <= cvs_pkg::RST_TGT_Y;
            r_tgt_d  <= cvs_pkg::RST_TGT_D;
            r_tstep  <= cvs_pkg::RST_TSTEP;
        end else if (i_cfg_we) begin
            unique case (cvs_pkg::t_cfg_idx'(i_cfg_idx))
                cvs_pkg::CFG_FOCAL:  r_focal  <= i_cfg_data;
                cvs_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                cvs_pkg::CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                cvs_pkg::CFG_DIAM:   r_diam   <= i_cfg_data;
                cvs_pkg::CFG_TGT_X:  r_tgt_x  <= i_cfg_data[15:0];
                cvs_pkg::CFG_TGT_Y:  r_tgt_y  <= i_cfg_data[15:0];
                cvs_pkg::CFG_TGT_D:  r_tgt_d  <= i_cfg_data[15:0];
                cvs_pkg::CFG_TSTEP:  r_tstep  <= i_cfg_data;
            endcase
        end
    end

    cvs_front u_front (
        .i_center_x        (i_center_x),
        .i_center_y        (i_center_y),
        .i_radius          (i_radius),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_quat_w          (i_quat_w),
        .i_quat_x          (i_quat_x),
        .i_quat_y          (i_quat_y),
        .i_quat_z          (i_quat_z),
        .i_image_width     (r_width),
        .i_image_height    (r_height),
        .i_target_x        (r_tgt_x),
        .i_target_y        (r_tgt_y),
        .i_target_diameter (r_tgt_d),
        .o_work            (fr_work)
    );

    // Decouple the front from the long-running back.
    cvs_queue #(
        .T     (cvs_pkg::t_work),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_work),
        .o_full  (full),
        .i_pop   (work_pop),
        .o_empty (work_empty),
        .o_data  (q_work)
    );

    cvs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work          (q_work),
        .i_work_valid    (!work_empty),
        .o_work_pop      (work_pop),
        .i_focal_length  (r_focal),
        .i_real_diameter (r_diam),
        .i_time_step     (r_tstep),
        .o_res           (bk_res),
        .o_res_push      (res_push),
        .i_res_full      (res_full)
    );

    // Buffer results so a stalled receiver does not stop the back at once.
    cvs_queue #(
        .T     (cvs_pkg::t_result),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (bk_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_cmd_x     = out_res.cmd_x;
    assign o_cmd_y     = out_res.cmd_y;
    assign o_cmd_z     = out_res.cmd_z;
    assign o_no_target = out_res.no_target;
    assign o_saturated = out_res.saturated;

endmodule

`default_nettype wire

// ----- design/cvs_queue.sv -----
// Small first-in first-out queue of register entries.
`default_nettype none

module cvs_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire T     i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output T          o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/cvs_front.sv -----
// Front stage: forms feature errors and centered coordinates, flags missing targets.
`default_nettype none

module cvs_front (
    input  wire logic               [15:0] i_center_x,
    input  wire logic               [15:0] i_center_y,
    input  wire logic               [15:0] i_radius,
    input  wire logic signed        [31:0] i_pos_x,
    input  wire logic signed        [31:0] i_pos_y,
    input  wire logic signed        [31:0] i_pos_z,
    input  wire logic signed        [31:0] i_quat_w,
    input  wire logic signed        [31:0] i_quat_x,
    input  wire logic signed        [31:0] i_quat_y,
    input  wire logic signed        [31:0] i_quat_z,
    input  wire logic               [12:0] i_image_width,
    input  wire logic               [12:0] i_image_height,
    input  wire logic               [15:0] i_target_x,
    input  wire logic               [15:0] i_target_y,
    input  wire logic               [15:0] i_target_diameter,
    output cvs_pkg::t_work                 o_work
);

    always_comb begin
        o_work.no_tgt = (i_radius == '0);
        o_work.e0 = signed'({1'b0, i_target_x}) - signed'({1'b0, i_center_x});
        o_work.e1 = signed'({1'b0, i_target_y}) - signed'({1'b0, i_center_y});
        o_work.e2 = signed'({2'b0, i_target_diameter}) - signed'({1'b0, i_radius, 1'b0});
        o_work.u  = signed'({2'b0, i_center_x}) - signed'({2'b0, i_image_width, 3'b0});
        o_work.v  = signed'({2'b0, i_center_y}) - signed'({2'b0, i_image_height, 3'b0});
        o_work.rad   = i_radius;
        o_work.pos_x = i_pos_x;
        o_work.pos_y = i_pos_y;
        o_work.pos_z = i_pos_z;
        o_work.qw    = i_quat_w;
        o_work.qx    = i_quat_x;
        o_work.qy    = i_quat_y;
        o_work.qz    = i_quat_z;
    end

endmodule

`default_nettype wire

// ----- design/cvs_div.sv -----
// Iterative floor divider: signed 64-bit dividend by positive 16-bit divisor.
`default_nettype none

module cvs_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic        [15:0] i_den,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [63:0]      o_quo
);

    localparam int NW    = 64;
    localparam int DW    = 16;
    localparam int STEP  = 8;
    localparam int CNT_W = $clog2(NW / STEP);

    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NW-1:0]    n_quo;
    logic [DW-1:0]    n_rem;

    // Advance STEP quotient bits per cycle; floor for negatives via one's complement.
    always_comb begin
        logic [DW:0]   rem;
        logic [NW-1:0] quo;
        rem = {1'b0, r_rem};
        quo = r_quo;
        for (int k = 0; k < STEP; k++) begin
            rem = {rem[DW-1:0], quo[NW-1]};
            quo = {quo[NW-2:0], 1'b0};
            if (rem >= {1'b0, r_den}) begin
                rem    = rem - {1'b0, r_den};
                quo[0] = 1'b1;
            end
        end
        n_rem = rem[DW-1:0];
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NW-1];
            r_quo <= i_num[NW-1] ? ~i_num : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW / STEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_neg ? ~r_quo : r_quo;

endmodule

`default_nettype wire

// ----- design/cvs_back.sv -----
// Back sequencer: depth, Jacobian inverse, rotation and position update on shared units.
`default_nettype none

module cvs_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cvs_pkg::t_work  i_work,
    input  wire logic            i_work_valid,
    output logic                 o_work_pop,
    input  wire logic [31:0]     i_focal_length,
    input  wire logic [31:0]     i_real_diameter,
    input  wire logic [31:0]     i_time_step,
    output cvs_pkg::t_result     o_res,
    output logic                 o_res_push,
    input  wire logic            i_res_full
);

    localparam logic signed [39:0] ONE_Q30 = 40'sd1073741824;

    cvs_pkg::t_bk_state r_state, n_state;
    cvs_pkg::t_work     r_w;
    logic signed [65:0] r_prod;
    logic [1:0]         r_idx;
    logic [1:0]         r_j;
    logic [3:0]         r_qi;
    logic signed [31:0] r_s   [3];
    logic [31:0]        r_k;
    logic signed [31:0] r_vc  [3];
    logic signed [31:0] r_ve  [3];
    logic signed [35:0] r_pq  [9];
    logic signed [31:0] r_rot [9];
    logic signed [35:0] r_acc;
    logic signed [31:0] r_cmd [3];
    logic               r_clip;

    logic               mul_en;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] prod5;
    logic               div_start;
    logic signed [63:0] div_num;
    logic [15:0]        div_den;
    logic               div_busy;
    logic               div_done;
    logic signed [63:0] div_quo;
    logic signed [31:0] vb;
    logic [3:0]         rot_idx;
    logic signed [39:0] rot_raw [9];
    logic signed [65:0] s_err;
    logic signed [31:0] pos_sel;
    logic signed [71:0] cmd_sum;

    cvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign mul_p   = mul_a * mul_b;
    assign prod5   = (r_prod <<< 2) + r_prod;
    assign vb      = cvs_pkg::sat32(72'(r_acc));
    assign rot_idx = 4'(r_idx) * 4'd3 + 4'(r_j);
    assign s_err   = 66'(div_quo) - 66'(r_idx == 2'd0 ? r_w.e0 : r_w.e1) * 66'sd10;

    always_comb begin
        unique case (r_idx)
            2'd0:    pos_sel = r_w.pos_x;
            2'd1:    pos_sel = r_w.pos_y;
            default: pos_sel = r_w.pos_z;
        endcase
        cmd_sum = 72'(pos_sel) + 72'(r_prod >>> 28);
    end

    // Rotation matrix from the stored quaternion products.
    always_comb begin
        rot_raw[0] = ONE_Q30 - 40'(r_pq[1] + r_pq[2]) * 2;
        rot_raw[1] = 40'(r_pq[3] - r_pq[8]) * 2;
        rot_raw[2] = 40'(r_pq[4] + r_pq[7]) * 2;
        rot_raw[3] = 40'(r_pq[3] + r_pq[8]) * 2;
        rot_raw[4] = ONE_Q30 - 40'(r_pq[0] + r_pq[2]) * 2;
        rot_raw[5] = 40'(r_pq[5] - r_pq[6]) * 2;
        rot_raw[6] = 40'(r_pq[4] - r_pq[7]) * 2;
        rot_raw[7] = 40'(r_pq[5] + r_pq[6]) * 2;
        rot_raw[8] = ONE_Q30 - 40'(r_pq[0] + r_pq[1]) * 2;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cvs_pkg::ST_IDLE: begin
                if (i_work_valid) begin
                    n_state = i_work.no_tgt ? cvs_pkg::ST_DONE : cvs_pkg::ST_MUL_UE;
                end
            end
            cvs_pkg::ST_MUL_UE:  n_state = cvs_pkg::ST_DIV_S0;
            cvs_pkg::ST_DIV_S0:  n_state = cvs_pkg::ST_WAIT_S0;
            cvs_pkg::ST_WAIT_S0: if (div_done) n_state = cvs_pkg::ST_DIV_S1;
            cvs_pkg::ST_DIV_S1:  n_state = cvs_pkg::ST_WAIT_S1;
            cvs_pkg::ST_WAIT_S1: if (div_done) n_state = cvs_pkg::ST_DIV_S2;
            cvs_pkg::ST_DIV_S2:  n_state = cvs_pkg::ST_WAIT_S2;
            cvs_pkg::ST_WAIT_S2: if (div_done) n_state = cvs_pkg::ST_DIV_K;
            cvs_pkg::ST_DIV_K:   n_state = cvs_pkg::ST_WAIT_K;
            cvs_pkg::ST_WAIT_K:  if (div_done) n_state = cvs_pkg::ST_MUL_V;
            cvs_pkg::ST_MUL_V:   n_state = cvs_pkg::ST_DIV_V;
            cvs_pkg::ST_DIV_V:   n_state = cvs_pkg::ST_WAIT_V;
            cvs_pkg::ST_WAIT_V: begin
                if (div_done) begin
                    n_state = (r_idx == 2'd2) ? cvs_pkg::ST_MUL_Q : cvs_pkg::ST_MUL_V;
                end
            end
            cvs_pkg::ST_MUL_Q:   n_state = cvs_pkg::ST_ACC_Q;
            cvs_pkg::ST_ACC_Q: begin
                n_state = (r_qi == 4'd8) ? cvs_pkg::ST_ROT : cvs_pkg::ST_MUL_Q;
            end
            cvs_pkg::ST_ROT:     n_state = cvs_pkg::ST_MUL_R;
            cvs_pkg::ST_MUL_R:   n_state = cvs_pkg::ST_ACC_R;
            cvs_pkg::ST_ACC_R: begin
                n_state = (r_j == 2'd2) ? cvs_pkg::ST_MUL_T : cvs_pkg::ST_MUL_R;
            end
            cvs_pkg::ST_MUL_T:   n_state = cvs_pkg::ST_CMD;
            cvs_pkg::ST_CMD: begin
                n_state = (r_idx == 2'd2) ? cvs_pkg::ST_DONE : cvs_pkg::ST_MUL_R;
            end
            cvs_pkg::ST_DONE:    if (!i_res_full) n_state = cvs_pkg::ST_IDLE;
            default:             n_state = cvs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_work_pop = 1'b0;
        o_res_push = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = r_w.rad;
        unique case (r_state)
            cvs_pkg::ST_IDLE:  o_work_pop = i_work_valid;
            cvs_pkg::ST_MUL_UE: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_w.u);
                mul_b  = 33'(r_w.e2);
            end
            cvs_pkg::ST_DIV_S0: begin
                div_start = 1'b1;
                div_num   = 64'(prod5);
                mul_en    = 1'b1;
                mul_a     = 33'(r_w.v);
                mul_b     = 33'(r_w.e2);
            end
            cvs_pkg::ST_DIV_S1: begin
                div_start = 1'b1;
                div_num   = 64'(prod5);
                mul_en    = 1'b1;
                mul_a     = signed'({1'b0, i_focal_length});
                mul_b     = 33'(r_w.e2);
            end
            cvs_pkg::ST_DIV_S2: begin
                div_start = 1'b1;
                div_num   = 64'(prod5 >>> 12);
            end
            cvs_pkg::ST_DIV_K: begin
                div_start = 1'b1;
                div_num   = signed'({28'b0, i_real_diameter, 4'b0});
            end
            cvs_pkg::ST_MUL_V: begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, r_k});
                mul_b  = 33'(r_s[r_idx]);
            end
            cvs_pkg::ST_DIV_V: begin
                // floor(p/1536) = floor(floor(p/512)/3)
                div_start = 1'b1;
                div_num   = 64'(r_prod >>> 9);
                div_den   = 16'd3;
            end
            cvs_pkg::ST_MUL_Q: begin
                mul_en = 1'b1;
                case (r_qi)
                    4'd0:    begin mul_a = 33'(r_w.qx); mul_b = 33'(r_w.qx); end
                    4'd1:    begin mul_a = 33'(r_w.qy); mul_b = 33'(r_w.qy); end
                    4'd2:    begin mul_a = 33'(r_w.qz); mul_b = 33'(r_w.qz); end
                    4'd3:    begin mul_a = 33'(r_w.qx); mul_b = 33'(r_w.qy); end
                    4'd4:    begin mul_a = 33'(r_w.qx); mul_b = 33'(r_w.qz); end
                    4'd5:    begin mul_a = 33'(r_w.qy); mul_b = 33'(r_w.qz); end
                    4'd6:    begin mul_a = 33'(r_w.qx); mul_b = 33'(r_w.qw); end
                    4'd7:    begin mul_a = 33'(r_w.qy); mul_b = 33'(r_w.qw); end
                    default: begin mul_a = 33'(r_w.qz); mul_b = 33'(r_w.qw); end
                endcase
            end
            cvs_pkg::ST_MUL_R: begin
                mul_en = 1'b1;
                mul_a  = 33'(r_rot[rot_idx]);
                mul_b  = 33'(r_ve[r_j]);
            end
            cvs_pkg::ST_MUL_T: begin
                mul_en = 1'b1;
                mul_a  = 33'(vb);
                mul_b  = signed'({1'b0, i_time_step});
            end
            cvs_pkg::ST_DONE:  o_res_push = !i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        unique case (r_state)
            cvs_pkg::ST_IDLE: begin
                if (i_work_valid) begin
                    r_w    <= i_work;
                    r_clip <= 1'b0;
                    r_idx  <= '0;
                    r_j    <= '0;
                    r_qi   <= '0;
                    r_acc  <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_cmd[i] <= '0;
                    end
                end
            end
            cvs_pkg::ST_WAIT_S0, cvs_pkg::ST_WAIT_S1: begin
                if (div_done) begin
                    r_s[r_idx] <= cvs_pkg::sat32(72'(s_err));
                    r_clip     <= r_clip | cvs_pkg::ovf32(72'(s_err));
                    r_idx      <= r_idx + 1'b1;
                end
            end
            cvs_pkg::ST_WAIT_S2: begin
                if (div_done) begin
                    r_s[2] <= cvs_pkg::sat32(72'(div_quo));
                    r_clip <= r_clip | cvs_pkg::ovf32(72'(div_quo));
                    r_idx  <= '0;
                end
            end
            cvs_pkg::ST_WAIT_K: begin
                if (div_done) begin
                    if (div_quo > 64'sh0_ffff_ffff) begin
                        r_k    <= '1;
                        r_clip <= 1'b1;
                    end else begin
                        r_k <= div_quo[31:0];
                    end
                end
            end
            cvs_pkg::ST_WAIT_V: begin
                if (div_done) begin
                    r_vc[r_idx] <= cvs_pkg::sat32(72'(div_quo));
                    r_clip      <= r_clip | cvs_pkg::ovf32(72'(div_quo));
                    r_idx       <= (r_idx == 2'd2) ? 2'd0 : r_idx + 1'b1;
                end
            end
            cvs_pkg::ST_ACC_Q: begin
                r_pq[r_qi] <= 36'(r_prod >>> 30);
                r_qi       <= r_qi + 1'b1;
            end
            cvs_pkg::ST_ROT: begin
                for (int i = 0; i < 9; i++) begin
                    r_rot[i] <= cvs_pkg::sat32(72'(rot_raw[i]));
                end
                // End-effector frame: x' = -y, y' = x, z' = z.
                r_ve[0] <= cvs_pkg::sat32(-72'(r_vc[1]));
                r_ve[1] <= r_vc[0];
                r_ve[2] <= r_vc[2];
                r_clip  <= r_clip | cvs_pkg::ovf32(-72'(r_vc[1]))
                         | cvs_pkg::ovf32(72'(rot_raw[0])) | cvs_pkg::ovf32(72'(rot_raw[1]))
                         | cvs_pkg::ovf32(72'(rot_raw[2])) | cvs_pkg::ovf32(72'(rot_raw[3]))
                         | cvs_pkg::ovf32(72'(rot_raw[4])) | cvs_pkg::ovf32(72'(rot_raw[5]))
                         | cvs_pkg::ovf32(72'(rot_raw[6])) | cvs_pkg::ovf32(72'(rot_raw[7]))
                         | cvs_pkg::ovf32(72'(rot_raw[8]));
            end
            cvs_pkg::ST_ACC_R: begin
                r_acc <= r_acc + 36'(r_prod >>> 30);
                r_j   <= (r_j == 2'd2) ? 2'd0 : r_j + 1'b1;
            end
            cvs_pkg::ST_MUL_T: begin
                r_clip <= r_clip | cvs_pkg::ovf32(72'(r_acc));
            end
            cvs_pkg::ST_CMD: begin
                r_cmd[r_idx] <= cvs_pkg::sat32(cmd_sum);
                r_clip       <= r_clip | cvs_pkg::ovf32(cmd_sum);
                r_acc        <= '0;
                r_idx        <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.cmd_x     = r_cmd[0];
        o_res.cmd_y     = r_cmd[1];
        o_res.cmd_z     = r_cmd[2];
        o_res.no_target = r_w.no_tgt;
        o_res.saturated = r_clip;
    end

`ifndef SYNTHESIS
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == cvs_pkg::ST_WAIT_S0 || r_state == cvs_pkg::ST_WAIT_S1 ||
                      r_state == cvs_pkg::ST_WAIT_S2 || r_state == cvs_pkg::ST_WAIT_K ||
                      r_state == cvs_pkg::ST_WAIT_V))
        else $error("division finished outside a wait state");

    a_no_tgt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && r_w.no_tgt) |->
            (!r_clip && r_cmd[0] == '0 && r_cmd[1] == '0 && r_cmd[2] == '0))
        else $error("missing target result not cleared");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cvs_pkg::ST_IDLE && o_work_pop) |=> (r_state != cvs_pkg::ST_IDLE))
        else $error("popped item not taken up");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_servo_checker.sv -----
// Checker for the circle visual servo step unit: predicts each result and compares it.
`timescale 1ns / 100ps

module tb_servo_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_idx,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic        [15:0] i_center_x,
    input  wire logic        [15:0] i_center_y,
    input  wire logic        [15:0] i_radius,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_quat_w,
    input  wire logic signed [31:0] i_quat_x,
    input  wire logic signed [31:0] i_quat_y,
    input  wire logic signed [31:0] i_quat_z,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic signed [31:0] i_cmd_x,
    input  wire logic signed [31:0] i_cmd_y,
    input  wire logic signed [31:0] i_cmd_z,
    input  wire logic               i_no_target,
    input  wire logic               i_saturated,
    output int                      o_fail_cnt,
    output int                      o_pending
);

    logic [31:0] focal_q, diam_q, tstep_q;
    logic [12:0] width_q, height_q;
    logic [15:0] tgt_x_q, tgt_y_q, tgt_d_q;

    cvs_pkg::t_result cmd_queue[$];

    assign o_pending = cmd_queue.size();

    function automatic longint clip32(input longint x, inout bit clipped);
        if (x > 64'sd2147483647) begin
            clipped = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clipped = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Floor division, positive divisor.
    function automatic longint floor_div(input longint n, input longint d);
        if (n >= 0) return n / d;
        return -1 - (-1 - n) / d;
    endfunction

    function automatic cvs_pkg::t_result servo_step(
        input longint cx, input longint cy, input longint r,
        input longint px, input longint py, input longint pz,
        input longint qw, input longint qx, input longint qy, input longint qz);
        cvs_pkg::t_result res;
        bit clipped;
        longint e0, e1, e2, u, v, k;
        longint s[3], vc[3], ve[3], pos[3], rot[3][3];
        longint pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw, acc, vb, stp;
        res = '0;
        clipped = 0;
        if (r == 0) begin
            res.no_target = 1'b1;
            return res;
        end
        pos[0] = px; pos[1] = py; pos[2] = pz;
        e0 = longint'(tgt_x_q) - cx;
        e1 = longint'(tgt_y_q) - cy;
        e2 = longint'(tgt_d_q) - 2 * r;
        u  = cx - 8 * longint'(width_q);
        v  = cy - 8 * longint'(height_q);
        k  = (longint'(diam_q) * 16) / r;
        if (k > 64'sh0ffffffff) begin
            k = 64'sh0ffffffff;
            clipped = 1;
        end
        s[0] = clip32(-10 * e0 + floor_div(5 * u * e2, r), clipped);
        s[1] = clip32(-10 * e1 + floor_div(5 * v * e2, r), clipped);
        s[2] = clip32(floor_div(5 * longint'(focal_q) * e2, r * 4096), clipped);
        for (int i = 0; i < 3; i++) vc[i] = clip32(floor_div(k * s[i], 1536), clipped);
        // Camera to end-effector axes.
        ve[0] = clip32(-vc[1], clipped);
        ve[1] = vc[0];
        ve[2] = vc[2];
        pxx = (qx * qx) >>> 30; pyy = (qy * qy) >>> 30; pzz = (qz * qz) >>> 30;
        pxy = (qx * qy) >>> 30; pxz = (qx * qz) >>> 30; pyz = (qy * qz) >>> 30;
        pxw = (qx * qw) >>> 30; pyw = (qy * qw) >>> 30; pzw = (qz * qw) >>> 30;
        rot[0][0] = (64'sd1 <<< 30) - 2 * (pyy + pzz);
        rot[0][1] = 2 * (pxy - pzw);
        rot[0][2] = 2 * (pxz + pyw);
        rot[1][0] = 2 * (pxy + pzw);
        rot[1][1] = (64'sd1 <<< 30) - 2 * (pxx + pzz);
        rot[1][2] = 2 * (pyz - pxw);
        rot[2][0] = 2 * (pxz - pyw);
        rot[2][1] = 2 * (pyz + pxw);
        rot[2][2] = (64'sd1 <<< 30) - 2 * (pxx + pyy);
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                rot[i][j] = clip32(rot[i][j], clipped);
                acc += (rot[i][j] * ve[j]) >>> 30;
            end
            vb  = clip32(acc, clipped);
            stp = (vb * longint'(tstep_q)) >>> 28;
            pos[i] = clip32(pos[i] + stp, clipped);
        end
        res.cmd_x = pos[0][31:0];
        res.cmd_y = pos[1][31:0];
        res.cmd_z = pos[2][31:0];
        res.saturated = clipped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        cvs_pkg::t_result want;
        if (!i_rst_n) begin
            focal_q <= cvs_pkg::RST_FOCAL;
            width_q <= cvs_pkg::RST_WIDTH;
            height_q <= cvs_pkg::RST_HEIGHT;
            diam_q <= cvs_pkg::RST_DIAM;
            tgt_x_q <= cvs_pkg::RST_TGT_X;
            tgt_y_q <= cvs_pkg::RST_TGT_Y;
            tgt_d_q <= cvs_pkg::RST_TGT_D;
            tstep_q <= cvs_pkg::RST_TSTEP;
            cmd_queue.delete();
            o_fail_cnt <= 0;
        end else begin
            if (i_cfg_we) begin
                case (cvs_pkg::t_cfg_idx'(i_cfg_idx))
                    cvs_pkg::CFG_FOCAL:  focal_q  <= i_cfg_data;
                    cvs_pkg::CFG_WIDTH:  width_q  <= i_cfg_data[12:0];
                    cvs_pkg::CFG_HEIGHT: height_q <= i_cfg_data[12:0];
                    cvs_pkg::CFG_DIAM:   diam_q   <= i_cfg_data;
                    cvs_pkg::CFG_TGT_X:  tgt_x_q  <= i_cfg_data[15:0];
                    cvs_pkg::CFG_TGT_Y:  tgt_y_q  <= i_cfg_data[15:0];
                    cvs_pkg::CFG_TGT_D:  tgt_d_q  <= i_cfg_data[15:0];
                    cvs_pkg::CFG_TSTEP:  tstep_q  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                cmd_queue.push_back(servo_step(i_center_x, i_center_y, i_radius,
                    i_pos_x, i_pos_y, i_pos_z, i_quat_w, i_quat_x, i_quat_y, i_quat_z));
            if (i_pop && !i_empty) begin
                if (cmd_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h %b %b",
                        $time, i_cmd_x, i_cmd_y, i_cmd_z, i_no_target, i_saturated);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = cmd_queue.pop_front();
                    if (want != {i_cmd_x, i_cmd_y, i_cmd_z, i_no_target, i_saturated}) begin
                        $display("%0t: mismatch expected %h %h %h nt=%b sat=%b",
                            $time, want.cmd_x, want.cmd_y, want.cmd_z,
                            want.no_target, want.saturated);
                        $display("%0t:          actual   %h %h %h nt=%b sat=%b",
                            $time, i_cmd_x, i_cmd_y, i_cmd_z, i_no_target, i_saturated);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the circle visual servo step unit: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb_top;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic        [2:0]  cfg_idx = '0;
    logic        [31:0] cfg_data = '0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full, empty, no_target, saturated;
    logic        [15:0] center_x = '0, center_y = '0, radius = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [31:0] cmd_x, cmd_y, cmd_z;
    int                 fail_cnt, pending;
    bit                 hold_off = 0;   // long receiver stall request

    always #6 clk = ~clk;

    circle_visual_servo_step_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .push(push), .full(full),
        .i_center_x(center_x), .i_center_y(center_y), .i_radius(radius),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_quat_w(quat_w), .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z),
        .empty(empty), .pop(pop),
        .o_cmd_x(cmd_x), .o_cmd_y(cmd_y), .o_cmd_z(cmd_z),
        .o_no_target(no_target), .o_saturated(saturated)
    );

    tb_servo_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_push(push), .i_full(full),
        .i_center_x(center_x), .i_center_y(center_y), .i_radius(radius),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_quat_w(quat_w), .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z),
        .i_empty(empty), .i_pop(pop),
        .i_cmd_x(cmd_x), .i_cmd_y(cmd_y), .i_cmd_z(cmd_z),
        .i_no_target(no_target), .i_saturated(saturated),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // Receiver: stall on its own pattern; hold off long when asked.
    initial begin
        int mode;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                pop <= 1'b0;
                repeat (1500) @(posedge clk);
                hold_off = 0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 4)      pop <= 1'b1;
            else if (mode < 8) pop <= ($urandom_range(0, 3) != 0);
            else               pop <= 1'b0;
        end
    end

    // Write one register while the block is idle.
    task automatic write_reg(input cvs_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item and hold it until accepted.
    task automatic send_circle(input logic [15:0] cx, cy, r,
                               input logic [31:0] px, py, pz, qw, qx, qy, qz);
        push <= 1'b1;
        center_x <= cx; center_y <= cy; radius <= r;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every expected result, then let the back finish.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'sd1 <<< 30 : -(32'sd1 <<< 30);
            default: return $urandom();
        endcase
    endfunction

    // Send one random item, mostly plausible circles and unit-ish quaternions.
    task automatic send_random();
        logic [15:0] cx, cy, r;
        logic [31:0] qw, qx, qy, qz;
        if ($urandom_range(0, 3) != 0) begin
            cx = $urandom_range(0, 640 * 16);
            cy = $urandom_range(0, 480 * 16);
            r  = $urandom_range(1, 200 * 16);
            qw = $signed($urandom_range(0, 2 ** 30)) - $signed($urandom_range(0, 2 ** 29));
            qx = $signed($urandom_range(0, 2 ** 29)) - (32'sd1 <<< 28);
            qy = $signed($urandom_range(0, 2 ** 29)) - (32'sd1 <<< 28);
            qz = $signed($urandom_range(0, 2 ** 29)) - (32'sd1 <<< 28);
        end else begin
            cx = $urandom(); cy = $urandom();
            r  = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom());
            qw = rand_word(); qx = rand_word(); qy = rand_word(); qz = rand_word();
        end
        send_circle(cx, cy, r, $urandom_range(0, 3) ? $signed($urandom()) >>> 4 : rand_word(),
            $signed($urandom()) >>> 4, rand_word(), qw, qx, qy, qz);
    endtask

    task automatic random_phase(input int count);
        int left;
        left = count;
        while (left > 0) begin
            // Burst of random length, then a random gap (sometimes none).
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
                send_random();
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 300));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, field extremes and special cases.
        send_circle(16'd5120, 16'd3840, 16'd800, 0, 0, 0, 32'sd1 <<< 30, 0, 0, 0);
        send_circle(16'd0, 16'd0, 16'd0, 32'h7fffffff, 0, 0, 32'sd1 <<< 30, 0, 0, 0);
        send_circle(16'hffff, 16'hffff, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_circle(16'd0, 16'd0, 16'd1, 32'h80000000, 32'h7fffffff, 32'h80000000,
            32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_circle(16'd1000, 16'd9000, 16'd16, 32'h01000000, 32'hff000000, 0,
            0, 0, 32'sd1 <<< 29, 32'sd1 <<< 29);
        send_circle(16'd2560, 16'd1920, 16'd400, 32'h00ffffff, 0, 32'hff000000,
            32'h2d413ccd, 32'h2d413ccd, 0, 0);
        send_circle(16'haaaa, 16'h5555, 16'h5555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
            32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
        drain();

        // Zero focal length, zero diameter, zero sensor size, zero time step.
        write_reg(cvs_pkg::CFG_FOCAL, 32'd0);
        write_reg(cvs_pkg::CFG_DIAM, 32'd0);
        write_reg(cvs_pkg::CFG_WIDTH, 32'd0);
        write_reg(cvs_pkg::CFG_HEIGHT, 32'd0);
        write_reg(cvs_pkg::CFG_TSTEP, 32'd0);
        send_circle(16'd300, 16'd300, 16'd100, 32'h100, 32'h200, 32'h300, 32'sd1 <<< 30, 0, 0, 0);
        send_circle(16'hffff, 16'd0, 16'd1, 0, 0, 0, 0, 32'sd1 <<< 30, 0, 0);
        drain();

        // Largest values in most registers; odd sensor size, extra bits masked.
        write_reg(cvs_pkg::CFG_FOCAL, 32'hffffffff);
        write_reg(cvs_pkg::CFG_DIAM, 32'hffffffff);
        write_reg(cvs_pkg::CFG_WIDTH, 32'hffff_f001);
        write_reg(cvs_pkg::CFG_HEIGHT, 32'd4096);
        write_reg(cvs_pkg::CFG_TGT_X, 32'hffffffff);
        write_reg(cvs_pkg::CFG_TGT_Y, 32'd0);
        write_reg(cvs_pkg::CFG_TGT_D, 32'hffff);
        write_reg(cvs_pkg::CFG_TSTEP, 32'hffffffff);
        send_circle(16'd0, 16'hffff, 16'd1, 0, 0, 0, 32'sd1 <<< 30, 0, 0, 0);
        send_circle(16'd100, 16'd100, 16'hffff, 32'h7fffffff, 32'h80000000, 0,
            32'sd1 <<< 30, 0, 0, 0);
        send_circle(16'd1, 16'd1, 16'd0, 32'h1, 32'h1, 32'h1, 0, 0, 0, 0);
        drain();

        // Random phases across several settings; settle before each reconfiguration.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(cvs_pkg::CFG_FOCAL,
                ph == 0 ? cvs_pkg::RST_FOCAL : 32'($urandom_range(0, 2000 << 16)));
            write_reg(cvs_pkg::CFG_WIDTH, $urandom_range(1, 4096));
            write_reg(cvs_pkg::CFG_HEIGHT, $urandom_range(1, 4096));
            write_reg(cvs_pkg::CFG_DIAM,
                ph == 1 ? 32'hffffffff : 32'($urandom_range(0, 1 << 28)));
            write_reg(cvs_pkg::CFG_TGT_X, $urandom_range(0, 65535));
            write_reg(cvs_pkg::CFG_TGT_Y, $urandom_range(0, 65535));
            write_reg(cvs_pkg::CFG_TGT_D, $urandom_range(0, 65535));
            write_reg(cvs_pkg::CFG_TSTEP, ph == 2 ? 32'hffffffff : 32'($urandom()));
            if (ph == 3) begin
                // Long receiver stall while items keep coming, to fill the block.
                hold_off = 1;
                repeat (12) send_random();
            end
            random_phase(120);
            if (ph == 4) drain();   // sender waits for every result
        end
        drain();
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/cvs_pkg.sv
design/cvs_queue.sv
design/cvs_front.sv
design/cvs_div.sv
design/cvs_back.sv
design/circle_visual_servo_step_unit.sv
dv/tb_servo_checker.sv
dv/tb_top.sv
